// File: rtl/core/ltgf_pkg.sv
// ----------------------------------------------------------------------------
// ltgf_pkg - local telemetry to geodetic fields
// Register indexes, reset values and fixed-point constants shared by the
// conversion datapath and its port checker.
// ----------------------------------------------------------------------------
package ltgf_pkg;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_HB_INTERVAL = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_LAT  = 3'd1;
  localparam cfg_idx_t REG_ORIGIN_LON  = 3'd2;
  localparam cfg_idx_t REG_LAT_GAIN    = 3'd3;
  localparam cfg_idx_t REG_LON_GAIN    = 3'd4;

  localparam logic        [15:0] HB_INTERVAL_RST = 16'd1000;
  localparam logic signed [30:0] ORIGIN_LAT_RST  = 31'sd504501000;
  localparam logic signed [31:0] ORIGIN_LON_RST  = 32'sd305234000;
  localparam logic        [23:0] LAT_GAIN_RST    = 24'd1507116;
  localparam logic        [23:0] LON_GAIN_RST    = 24'd2366879;

  // Heading: centidegrees per radian, Q16, applied to a Q16 angle -> Q32
  localparam logic signed [29:0] HEAD_K        = 30'sd375493621;
  localparam logic        [15:0] HEAD_MOD_CDEG = 16'd36000;
  localparam logic        [15:0] HEAD_MAX_CDEG = 16'd35999;
  // 9000 cdeg base plus 8192 full turns, keeps the integer heading positive
  localparam logic        [28:0] HEAD_BIAS     = 29'd294921000;
  localparam int                 HEAD_RECIP_SHIFT = 44;
  localparam logic        [28:0] HEAD_RECIP    =
    29'((64'd1 << HEAD_RECIP_SHIFT) / 64'd36000);

  // Yaw in radians Q32
  localparam logic signed [48:0] HALF_PI_Q32 = 49'sd6746518852;
  localparam logic        [34:0] PI_Q32      = 35'd13493037705;
  localparam logic        [34:0] TWO_PI_Q32  = 35'd26986075409;
  // 5216 full turns, keeps the Q32 yaw positive before the turn count
  localparam logic        [48:0] YAW_BIAS    = 49'(64'd5216 * 64'd26986075409);
  localparam int                 YAW_PRE_SHIFT   = 18;
  localparam int                 YAW_RECIP_SHIFT = 41;
  localparam logic        [24:0] YAW_RECIP   =
    25'((64'd1 << (YAW_PRE_SHIFT + YAW_RECIP_SHIFT)) / 64'd26986075409);
  localparam logic signed [18:0] YAW_MAX_Q16 = 19'sd205887;

  // Velocity mm/s -> cm/s
  localparam int           VEL_RECIP_SHIFT = 24;
  localparam logic [20:0]  VEL_RECIP   = 21'((64'd1 << VEL_RECIP_SHIFT) / 64'd10);
  localparam logic [18:0]  VEL_N_CLAMP = 19'd327690;

  // Fields that ride along the pipe untouched
  typedef struct packed {
    logic        hb;
    logic [31:0] stamp;
    logic [31:0] alt;
  } carry_t;

endpackage

// File: rtl/core/local_telemetry_to_geodetic_fields_unit.sv
// ----------------------------------------------------------------------------
// local_telemetry_to_geodetic_fields_unit
// Flat-earth conversion of a local telemetry sample into position-report
// fields, with heartbeat request tracking.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | in_valid / in_ready   | time, position, velocity, dir
//  out     | source    | out_valid / out_ready | heartbeat flag, geodetic fields
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Five register stages, one sample per cycle unless a stall on out_ready holds the pipe.
//  The widest step in any stage is a multiply (gains, heading scale, and the
//  reciprocal turn counts for heading and yaw).
//  Each stage has its own valid bit and advances into a bubble, so a stall on
//  out_ready only backs up as far as the first empty stage.
//  Synchronous reset empties the pipe and restores the registers.
// ----------------------------------------------------------------------------
module local_telemetry_to_geodetic_fields_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [31:0]             time_ms,
  input  logic signed [31:0]      east_mm,
  input  logic signed [31:0]      north_mm,
  input  logic signed [31:0]      up_mm,
  input  logic signed [23:0]      vel_x_mm_s,
  input  logic signed [23:0]      vel_y_mm_s,
  input  logic signed [31:0]      direction_q16,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    send_heartbeat,
  output logic [31:0]             stamp_ms,
  output logic signed [31:0]      lat_e7,
  output logic signed [31:0]      lon_e7,
  output logic signed [31:0]      alt_mm,
  output logic signed [15:0]      vel_x_cm_s,
  output logic signed [15:0]      vel_y_cm_s,
  output logic [15:0]             heading_cdeg,
  output logic signed [18:0]      yaw_q16,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  ltgf_pkg::cfg_idx_t      cfg_index,
  input  logic [31:0]             cfg_data
);
  import ltgf_pkg::*;

  // |v|+5, clamped where the cm/s value is saturated anyway
  function automatic logic [18:0] vel_prep(input logic signed [23:0] v);
    logic [23:0] mag;
    logic [24:0] n;
    mag = v[23] ? 24'(-v) : 24'(v);
    n   = 25'(mag) + 25'd5;
    return (n > 25'(VEL_N_CLAMP)) ? VEL_N_CLAMP : n[18:0];
  endfunction

  // quotient correction, sign and int16 saturation
  function automatic logic signed [15:0] vel_final(input logic [18:0] n,
                                                   input logic [15:0] q,
                                                   input logic neg);
    logic [18:0] rem;
    logic [15:0] qf;
    rem = n - 19'(q) * 19'd10;
    qf  = (rem >= 19'd10) ? q + 16'd1 : q;
    if (neg) begin
      return (qf > 16'd32768) ? -16'sd32768 : 16'(-qf);
    end else begin
      return (qf > 16'd32767) ? 16'sd32767 : 16'(qf);
    end
  endfunction

  // divide by 2^24, half away from zero, saturate to int32
  function automatic logic signed [31:0] geo_round(input logic signed [57:0] t);
    logic signed [57:0] r;
    logic signed [33:0] q;
    r = t + (t[57] ? 58'sd8388607 : 58'sd8388608);
    q = r[57:24];
    if (q[33:31] == 3'b000 || q[33:31] == 3'b111) begin
      return q[31:0];
    end else begin
      return q[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [15:0]        hb_interval;
  logic signed [30:0] origin_lat;
  logic signed [31:0] origin_lon;
  logic [23:0]        lat_gain;
  logic [23:0]        lon_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_interval <= HB_INTERVAL_RST;
      origin_lat  <= ORIGIN_LAT_RST;
      origin_lon  <= ORIGIN_LON_RST;
      lat_gain    <= LAT_GAIN_RST;
      lon_gain    <= LON_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HB_INTERVAL: hb_interval <= cfg_data[15:0];
        REG_ORIGIN_LAT:  origin_lat  <= cfg_data[30:0];
        REG_ORIGIN_LON:  origin_lon  <= cfg_data;
        REG_LAT_GAIN:    lat_gain    <= cfg_data[23:0];
        REG_LON_GAIN:    lon_gain    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe control
  // --------------------------------------------------------------------------
  logic [5:1] stg_vld;
  logic [5:1] stg_adv;

  always_comb begin
    stg_adv[5] = !stg_vld[5] || out_ready;
    for (int k = 4; k >= 1; k--) begin
      stg_adv[k] = !stg_vld[k] || stg_adv[k+1];
    end
  end

  assign in_ready  = stg_adv[1];
  assign out_valid = stg_vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= '0;
    end else begin
      if (stg_adv[1]) stg_vld[1] <= in_valid;
      for (int k = 2; k <= 5; k++) begin
        if (stg_adv[k]) stg_vld[k] <= stg_vld[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Heartbeat tracking, decided on the input transfer
  // --------------------------------------------------------------------------
  logic        hb_seen;
  logic [31:0] hb_last_ms;
  logic [31:0] hb_elapsed;
  logic        hb_now;

  assign hb_elapsed = time_ms - hb_last_ms;
  assign hb_now = !hb_seen || (time_ms < hb_last_ms) ||
                  (hb_elapsed >= 32'(hb_interval));

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_seen    <= 1'b0;
      hb_last_ms <= '0;
    end else if (in_valid && in_ready && hb_now) begin
      hb_seen    <= 1'b1;
      hb_last_ms <= time_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  carry_t             s1_carry;
  logic signed [31:0] s1_east, s1_north, s1_dir;
  logic signed [23:0] s1_vx, s1_vy;

  always_ff @(posedge clk) begin
    if (stg_adv[1]) begin
      s1_carry <= '{hb: hb_now, stamp: time_ms, alt: up_mm};
      s1_east  <= east_mm;
      s1_north <= north_mm;
      s1_dir   <= direction_q16;
      s1_vx    <= vel_x_mm_s;
      s1_vy    <= vel_y_mm_s;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain and heading products, yaw offset, velocity prep
  // --------------------------------------------------------------------------
  carry_t             s2_carry;
  logic signed [56:0] s2_lat_prod, s2_lon_prod;
  logic signed [60:0] s2_head_prod;
  logic [48:0]        s2_yaw_u;
  logic               s2_yaw_neg;
  logic [18:0]        s2_vx_n, s2_vy_n;
  logic               s2_vx_neg, s2_vy_neg;
  logic signed [48:0] yaw_y;

  assign yaw_y = HALF_PI_Q32 - (49'(s1_dir) <<< 16);

  always_ff @(posedge clk) begin
    if (stg_adv[2]) begin
      s2_carry     <= s1_carry;
      s2_lat_prod  <= 57'(s1_north) * 57'(lat_gain);
      s2_lon_prod  <= 57'(s1_east) * 57'(lon_gain);
      s2_head_prod <= 61'(s1_dir) * 61'(HEAD_K);
      s2_yaw_u     <= 49'(50'(yaw_y) + 50'(YAW_BIAS));
      s2_yaw_neg   <= yaw_y[48];
      s2_vx_n      <= vel_prep(s1_vx);
      s2_vy_n      <= vel_prep(s1_vy);
      s2_vx_neg    <= s1_vx[23];
      s2_vy_neg    <= s1_vy[23];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: origin sums, integer heading, turn and tenth estimates
  // --------------------------------------------------------------------------
  carry_t             s3_carry;
  logic signed [57:0] s3_lat_t, s3_lon_t;
  logic [28:0]        s3_head_x;
  logic [48:0]        s3_yaw_u;
  logic               s3_yaw_neg;
  logic [14:0]        s3_yaw_q;
  logic [18:0]        s3_vx_n, s3_vy_n;
  logic               s3_vx_neg, s3_vy_neg;
  logic [15:0]        s3_vx_q, s3_vy_q;
  logic signed [61:0] head_num;
  logic [29:0]        head_int;
  logic [55:0]        yaw_prod;
  logic [39:0]        vx_prod, vy_prod;

  // floor((2^31 - P) / 2^32) rounds the Q32 heading half up
  assign head_num = 62'sh8000_0000 - 62'(s2_head_prod);
  assign head_int = head_num[61:32];
  assign yaw_prod = 56'(s2_yaw_u[48:YAW_PRE_SHIFT]) * 56'(YAW_RECIP);
  assign vx_prod  = 40'(s2_vx_n) * 40'(VEL_RECIP);
  assign vy_prod  = 40'(s2_vy_n) * 40'(VEL_RECIP);

  always_ff @(posedge clk) begin
    if (stg_adv[3]) begin
      s3_carry   <= s2_carry;
      s3_lat_t   <= (58'(origin_lat) <<< 24) + 58'(s2_lat_prod);
      s3_lon_t   <= (58'(origin_lon) <<< 24) + 58'(s2_lon_prod);
      s3_head_x  <= 29'(head_int + 30'(HEAD_BIAS));
      s3_yaw_u   <= s2_yaw_u;
      s3_yaw_neg <= s2_yaw_neg;
      s3_yaw_q   <= yaw_prod[55:YAW_RECIP_SHIFT];
      s3_vx_n    <= s2_vx_n;
      s3_vy_n    <= s2_vy_n;
      s3_vx_neg  <= s2_vx_neg;
      s3_vy_neg  <= s2_vy_neg;
      s3_vx_q    <= vx_prod[39:VEL_RECIP_SHIFT];
      s3_vy_q    <= vy_prod[39:VEL_RECIP_SHIFT];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: lat/lon and velocity done, heading turn estimate, yaw remainder
  // --------------------------------------------------------------------------
  carry_t             s4_carry;
  logic signed [31:0] s4_lat, s4_lon;
  logic signed [15:0] s4_vx, s4_vy;
  logic [28:0]        s4_head_x;
  logic [13:0]        s4_head_q;
  logic [34:0]        s4_yaw_r;
  logic               s4_yaw_neg;
  logic [57:0]        head_prod;
  logic [35:0]        yaw_rem;

  assign head_prod = 58'(s3_head_x) * 58'(HEAD_RECIP);
  // estimate is low by at most one turn
  assign yaw_rem   = 36'(s3_yaw_u - 49'(s3_yaw_q) * 49'(TWO_PI_Q32));

  always_ff @(posedge clk) begin
    if (stg_adv[4]) begin
      s4_carry   <= s3_carry;
      s4_lat     <= geo_round(s3_lat_t);
      s4_lon     <= geo_round(s3_lon_t);
      s4_vx      <= vel_final(s3_vx_n, s3_vx_q, s3_vx_neg);
      s4_vy      <= vel_final(s3_vy_n, s3_vy_q, s3_vy_neg);
      s4_head_x  <= s3_head_x;
      s4_head_q  <= head_prod[57:HEAD_RECIP_SHIFT];
      s4_yaw_r   <= (yaw_rem >= 36'(TWO_PI_Q32)) ? 35'(yaw_rem - 36'(TWO_PI_Q32))
                                                 : yaw_rem[34:0];
      s4_yaw_neg <= s3_yaw_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: result register
  // --------------------------------------------------------------------------
  carry_t             s5_carry;
  logic signed [31:0] s5_lat, s5_lon;
  logic signed [15:0] s5_vx, s5_vy;
  logic [15:0]        s5_head;
  logic signed [18:0] s5_yaw;
  logic [16:0]        head_rem;
  logic               yaw_keep;
  logic signed [35:0] yaw_r;
  logic signed [35:0] yaw_rnd;

  assign head_rem = 17'(s4_head_x - 29'(s4_head_q) * 29'(HEAD_MOD_CDEG));

  // The remainder's sign follows the dividend, so the two residues that sit
  // on both ends of the +-pi window resolve differently for negative input.
  assign yaw_keep = s4_yaw_neg ? (s4_yaw_r < PI_Q32 - 35'd1) : (s4_yaw_r <= PI_Q32);
  assign yaw_r    = yaw_keep ? 36'(s4_yaw_r) : 36'(s4_yaw_r) - 36'(TWO_PI_Q32);
  assign yaw_rnd  = yaw_r + (yaw_r[35] ? 36'sd32767 : 36'sd32768);

  always_ff @(posedge clk) begin
    if (stg_adv[5]) begin
      s5_carry <= s4_carry;
      s5_lat   <= s4_lat;
      s5_lon   <= s4_lon;
      s5_vx    <= s4_vx;
      s5_vy    <= s4_vy;
      s5_head  <= (head_rem >= 17'(HEAD_MOD_CDEG)) ? 16'(head_rem - 17'(HEAD_MOD_CDEG))
                                                   : head_rem[15:0];
      s5_yaw   <= yaw_rnd[34:16];
    end
  end

  assign send_heartbeat = s5_carry.hb;
  assign stamp_ms       = s5_carry.stamp;
  assign alt_mm         = s5_carry.alt;
  assign lat_e7         = s5_lat;
  assign lon_e7         = s5_lon;
  assign vel_x_cm_s     = s5_vx;
  assign vel_y_cm_s     = s5_vy;
  assign heading_cdeg   = s5_head;
  assign yaw_q16        = s5_yaw;

endmodule

// File: rtl/core/ltgf_checker.sv
// ----------------------------------------------------------------------------
// ltgf_checker - port checks for the geodetic fields unit
// Watches the top-level ports for range, reset and flow-control slips.
// ----------------------------------------------------------------------------
module ltgf_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_ready,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    send_heartbeat,
  input  logic [31:0]             stamp_ms,
  input  logic signed [31:0]      lat_e7,
  input  logic signed [31:0]      lon_e7,
  input  logic signed [31:0]      alt_mm,
  input  logic signed [15:0]      vel_x_cm_s,
  input  logic signed [15:0]      vel_y_cm_s,
  input  logic [15:0]             heading_cdeg,
  input  logic signed [18:0]      yaw_q16
);
  import ltgf_pkg::*;

  // heading wraps into one turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_cdeg <= HEAD_MAX_CDEG)
    else $error("heading out of range");

  // yaw stays inside +-pi
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw_q16 <= YAW_MAX_Q16 && yaw_q16 >= -YAW_MAX_Q16))
    else $error("yaw out of range");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lat_e7) && $stable(lon_e7) &&
      $stable(heading_cdeg) && $stable(yaw_q16) && $stable(stamp_ms) &&
      $stable(send_heartbeat) && $stable(alt_mm) && $stable(vel_x_cm_s) &&
      $stable(vel_y_cm_s))
    else $error("stalled result changed");

endmodule

bind local_telemetry_to_geodetic_fields_unit ltgf_checker u_ltgf_checker (.*);
